/* rtl/core/ris_pkg.sv */
// Shared types and constants for the read interval set core.
package ris_pkg;

   localparam int unsigned VAL_W = 31;
   localparam logic [VAL_W-1:0] V31_MAX = {VAL_W{1'b1}};
   localparam int unsigned OUT_LIMIT = 32;

   typedef enum logic [2:0] {
      MODE_MARK  = 3'd0,
      MODE_QUERY = 3'd1,
      MODE_FIRST = 3'd2,
      MODE_FIX   = 3'd3,
      MODE_CATCH = 3'd4,
      MODE_LOAD  = 3'd5,
      MODE_DUMP  = 3'd6,
      MODE_NONE  = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // saturate a 34-bit signed value to 0..2^31-1
   function automatic logic [VAL_W-1:0] sat31(input logic signed [33:0] v);
      logic [VAL_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 34'sd2147483647) begin
         r = V31_MAX;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/ris_table.sv */
// Dual range memory with one read port and one write port per bound.
module ris_table
   import ris_pkg::*;
#(
   parameter int MAX_RANGES = 32,
   localparam int AW = $clog2(MAX_RANGES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [VAL_W-1:0] wr_lo,
   input  logic [VAL_W-1:0] wr_hi,
   input  logic [AW-1:0]    rd_addr,
   output logic [VAL_W-1:0] rd_lo,
   output logic [VAL_W-1:0] rd_hi
);

   logic [VAL_W-1:0] lo_mem [MAX_RANGES];
   logic [VAL_W-1:0] hi_mem [MAX_RANGES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lo_mem[wr_addr] <= wr_lo;
         hi_mem[wr_addr] <= wr_hi;
      end
      rd_lo <= lo_mem[rd_addr];
      rd_hi <= hi_mem[rd_addr];
   end

endmodule

/* rtl/core/read_interval_set_core.sv */
// Top level of the read interval set core: sequencer around the range memory.
//
// Usage: pulse start with mode and operands while busy is low; the item is
// taken at that edge and busy rises the next cycle. Each result appears for
// one cycle with rsp_valid high; rsp_last marks the final result of the item.
// The receiver cannot stall, so results are never held back.
// csr_wr_en writes the subscribed bit; write it only while busy is low.
// Operation: the sequencer walks the range memory one entry at a time; each
// memory read is registered. A query or mark scans the entries in order until
// the scan stops, plus any merge or shift; a first-unread item reads only the
// first entry. An insert shifts the tail up one entry at a time from the top,
// a delete shifts the entries above down. Fix and catchup check the last and
// first entries, then may delete or insert; load reads the last entry and may
// insert. A dump gives its ranges in order, starting from the first entry.
// Busy drops with the last result; one item is in work at a time.
// Reset: the table empties, initial catchup becomes pending, subscribed is 1.
// The range memory itself is not cleared; a fill count bounds every use of read data.
module read_interval_set_core
   import ris_pkg::*;
#(
   parameter int MAX_RANGES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_mode,
   input  logic signed [31:0]  req_art_num,
   input  logic signed [31:0]  req_group_lo,
   input  logic signed [31:0]  req_group_hi,
   input  logic signed [31:0]  req_keep_count,
   input  logic signed [31:0]  req_range_first,
   input  logic signed [31:0]  req_range_second,
   output logic                rsp_valid,
   output logic                rsp_is_read,
   output logic [VAL_W-1:0]    rsp_value,
   output logic [VAL_W-1:0]    rsp_range_high,
   output logic [1:0]          rsp_status,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int AW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
   localparam logic [CW-1:0] OUT_MAX =
      (MAX_RANGES < OUT_LIMIT) ? CW'(MAX_RANGES) : CW'(OUT_LIMIT);

   typedef enum logic [4:0] {
      S_IDLE, S_RD, S_SCAN, S_MERGE_RD, S_MERGE, S_DEL_RD, S_DEL_WR,
      S_INS_RD, S_INS_WAIT, S_INS_WR, S_INS_PUT, S_FIX_RD, S_FIX_LAST,
      S_FIX_HEAD_RD, S_FIX_HEAD, S_LOAD, S_DUMP_RD, S_DUMP, S_DONE
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic catchup_ff;
   logic subscribed_ff;
   mode_type mode_ff;
   logic signed [33:0] art_ff, glo_ff, ghi_ff, ld_lo_ff, ld_hi_ff;
   logic ld_drop_ff;
   logic [CW-1:0] idx_ff;     // scan / shift position
   logic [CW-1:0] pos_ff;     // insert or merge position
   logic [VAL_W-1:0] ins_lo_ff, ins_hi_ff;
   logic [1:0] st_ff;
   logic is_read_ff;
   logic [VAL_W-1:0] val_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VAL_W-1:0] wr_lo, wr_hi, rd_lo, rd_hi;

   ris_table #(.MAX_RANGES(MAX_RANGES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_lo  (wr_lo),
      .wr_hi  (wr_hi),
      .rd_addr(rd_addr),
      .rd_lo  (rd_lo),
      .rd_hi  (rd_hi)
   );

   logic [AW-1:0] rd_addr_ff;
   logic wr_en_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [VAL_W-1:0] wr_lo_ff, wr_hi_ff;
   assign rd_addr = rd_addr_ff;
   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_lo   = wr_lo_ff;
   assign wr_hi   = wr_hi_ff;

   assign busy = (state_ff != S_IDLE);

   logic signed [33:0] rlo, rhi, cat_lo, ghi_lim;
   assign rlo = {3'b000, rd_lo};
   assign rhi = {3'b000, rd_hi};
   assign ghi_lim = ghi_ff + ((ghi_ff > 34'sd100) ? 34'sd4 : 34'sd0);

   logic signed [33:0] in_glo, in_ghi, in_keep, in_f, in_s, in_a, in_b, cat_base;
   always_comb begin
      in_glo  = 34'(req_group_lo);
      in_ghi  = 34'(req_group_hi);
      in_keep = 34'(req_keep_count);
      in_f    = 34'(req_range_first);
      in_s    = 34'(req_range_second);
      in_a    = (in_f >= 0) ? in_f : '0;
      in_b    = (in_s >= 0) ? in_s : '0;
      cat_base = in_ghi - in_keep + 34'sd1;
      if (cat_base < 34'sd1) begin
         cat_base = 34'sd1;
      end
      cat_lo = (cat_base > in_glo) ? cat_base : in_glo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         catchup_ff    <= 1'b1;
         subscribed_ff <= 1'b1;
         rsp_valid     <= 1'b0;
         rsp_last      <= 1'b0;
         wr_en_ff      <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         rsp_last  <= 1'b0;
         wr_en_ff  <= 1'b0;
         if (csr_wr_en) begin
            subscribed_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff    <= mode_type'(req_mode);
                  art_ff     <= 34'(req_art_num);
                  glo_ff     <= in_glo;
                  ghi_ff     <= in_ghi;
                  ld_lo_ff   <= ((in_a < in_b) ? in_a : in_b) == 0 ? 34'sd1 :
                                ((in_a < in_b) ? in_a : in_b);
                  ld_hi_ff   <= (in_a < in_b) ? in_b : in_a;
                  ld_drop_ff <= (in_a <= 0);
                  st_ff      <= ST_OK;
                  is_read_ff <= 1'b0;
                  val_ff     <= '0;
                  idx_ff     <= '0;
                  rd_addr_ff <= '0;
                  unique case (mode_type'(req_mode))
                     MODE_CATCH: begin
                        glo_ff <= cat_lo;
                        catchup_ff <= 1'b0;
                        state_ff <= S_FIX_LAST;
                     end
                     MODE_FIX: begin
                        if (catchup_ff && in_keep >= 0) begin
                           glo_ff <= cat_lo;
                        end
                        catchup_ff <= 1'b0;
                        state_ff <= S_FIX_LAST;
                     end
                     MODE_LOAD: begin
                        rd_addr_ff <= AW'(count_ff - CW'(1));
                        state_ff <= S_RD;
                     end
                     MODE_NONE: state_ff <= S_DONE;
                     default: state_ff <= S_RD;
                  endcase
                  if (mode_type'(req_mode) == MODE_FIX ||
                      mode_type'(req_mode) == MODE_CATCH) begin
                     rd_addr_ff <= AW'(count_ff - CW'(1));
                  end
               end
            end
            // read latency
            S_RD: begin
               unique case (mode_ff)
                  MODE_LOAD: state_ff <= S_LOAD;
                  MODE_DUMP: state_ff <= S_DUMP;
                  default: state_ff <= S_SCAN;
               endcase
               if (mode_ff == MODE_DUMP && count_ff == '0) begin
                  st_ff <= ST_EMPTY;
                  state_ff <= S_DONE;
               end
            end
            S_SCAN: begin
               // rd_lo/rd_hi hold entry idx_ff when idx_ff < count_ff
               unique case (mode_ff)
                  MODE_QUERY: begin
                     if (art_ff <= 0) begin
                        is_read_ff <= 1'b1;
                        state_ff <= S_DONE;
                     end else if (idx_ff >= count_ff || art_ff < rlo) begin
                        state_ff <= S_DONE;
                     end else if (art_ff <= rhi) begin
                        is_read_ff <= 1'b1;
                        state_ff <= S_DONE;
                     end else begin
                        idx_ff <= idx_ff + CW'(1);
                        rd_addr_ff <= AW'(idx_ff + CW'(1));
                        state_ff <= S_RD;
                     end
                  end
                  MODE_FIRST: begin
                     if (count_ff == '0 || glo_ff < rlo) begin
                        val_ff <= sat31(glo_ff);
                     end else begin
                        val_ff <= sat31(rhi + 34'sd1);
                     end
                     state_ff <= S_DONE;
                  end
                  default: begin // mark
                     if (!subscribed_ff || art_ff <= 0) begin
                        state_ff <= S_DONE;
                     end else if (idx_ff >= count_ff) begin
                        pos_ff <= count_ff;
                        ins_lo_ff <= sat31(art_ff);
                        ins_hi_ff <= sat31(art_ff);
                        state_ff <= S_INS_RD;
                        idx_ff <= count_ff;
                     end else if (art_ff < rlo - 34'sd1) begin
                        pos_ff <= idx_ff;
                        ins_lo_ff <= sat31(art_ff);
                        ins_hi_ff <= sat31(art_ff);
                        idx_ff <= count_ff;
                        state_ff <= S_INS_RD;
                     end else if (art_ff == rlo - 34'sd1) begin
                        wr_en_ff <= 1'b1;
                        wr_addr_ff <= AW'(idx_ff);
                        wr_lo_ff <= sat31(art_ff);
                        wr_hi_ff <= rd_hi;
                        state_ff <= S_DONE;
                     end else if (art_ff <= rhi) begin
                        state_ff <= S_DONE;
                     end else if (art_ff == rhi + 34'sd1) begin
                        ins_lo_ff <= rd_lo;
                        pos_ff <= idx_ff;
                        if (idx_ff + CW'(1) < count_ff) begin
                           rd_addr_ff <= AW'(idx_ff + CW'(1));
                           state_ff <= S_MERGE_RD;
                        end else begin
                           wr_en_ff <= 1'b1;
                           wr_addr_ff <= AW'(idx_ff);
                           wr_lo_ff <= rd_lo;
                           wr_hi_ff <= sat31(art_ff);
                           state_ff <= S_DONE;
                        end
                     end else begin
                        idx_ff <= idx_ff + CW'(1);
                        rd_addr_ff <= AW'(idx_ff + CW'(1));
                        state_ff <= S_RD;
                     end
                  end
               endcase
            end
            S_MERGE_RD: state_ff <= S_MERGE;
            S_MERGE: begin
               wr_en_ff <= 1'b1;
               wr_addr_ff <= AW'(pos_ff);
               wr_lo_ff <= ins_lo_ff;
               if (art_ff == rlo - 34'sd1) begin
                  wr_hi_ff <= rd_hi;
                  idx_ff <= pos_ff + CW'(1);
                  state_ff <= S_DEL_RD;
                  rd_addr_ff <= AW'(pos_ff + CW'(2));
               end else begin
                  wr_hi_ff <= sat31(art_ff);
                  state_ff <= S_DONE;
               end
            end
            // delete entry idx_ff: shift entries above down
            S_DEL_RD: begin
               if (idx_ff + CW'(1) >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= (mode_ff == MODE_FIX || mode_ff == MODE_CATCH) ?
                              S_FIX_HEAD_RD : S_DONE;
                  rd_addr_ff <= '0;
               end else begin
                  state_ff <= S_DEL_WR;
               end
            end
            S_DEL_WR: begin
               wr_en_ff <= 1'b1;
               wr_addr_ff <= AW'(idx_ff);
               wr_lo_ff <= rd_lo;
               wr_hi_ff <= rd_hi;
               idx_ff <= idx_ff + CW'(1);
               rd_addr_ff <= AW'(idx_ff + CW'(2));
               state_ff <= S_DEL_RD;
            end
            // insert at pos_ff: shift tail up from the top
            S_INS_RD: begin
               if (count_ff >= CNT_MAX) begin
                  st_ff <= ST_FULL;
                  state_ff <= S_DONE;
               end else if (idx_ff == pos_ff) begin
                  state_ff <= S_INS_PUT;
               end else begin
                  rd_addr_ff <= AW'(idx_ff - CW'(1));
                  state_ff <= S_INS_WAIT;
               end
            end
            S_INS_WAIT: state_ff <= S_INS_WR;
            S_INS_WR: begin
               wr_en_ff <= 1'b1;
               wr_addr_ff <= AW'(idx_ff);
               wr_lo_ff <= rd_lo;
               wr_hi_ff <= rd_hi;
               idx_ff <= idx_ff - CW'(1);
               state_ff <= S_INS_RD;
            end
            S_INS_PUT: begin
               wr_en_ff <= 1'b1;
               wr_addr_ff <= AW'(pos_ff);
               wr_lo_ff <= ins_lo_ff;
               wr_hi_ff <= ins_hi_ff;
               count_ff <= count_ff + CW'(1);
               if (mode_ff == MODE_LOAD) begin
                  catchup_ff <= 1'b0;
               end
               state_ff <= S_DONE;
            end
            // fix and catchup: check last high bound
            S_FIX_LAST: state_ff <= S_FIX_RD;
            S_FIX_RD: begin
               if (count_ff != '0 && rhi > ghi_lim) begin
                  count_ff <= '0;
               end
               rd_addr_ff <= '0;
               state_ff <= S_FIX_HEAD_RD;
            end
            S_FIX_HEAD_RD: state_ff <= S_FIX_HEAD;
            S_FIX_HEAD: begin
               if (count_ff != '0 && glo_ff > rhi) begin
                  idx_ff <= '0;
                  rd_addr_ff <= AW'(CW'(1));
                  state_ff <= S_DEL_RD;
               end else if (count_ff == '0 || glo_ff < rlo) begin
                  if (glo_ff > 34'sd1) begin
                     pos_ff <= '0;
                     idx_ff <= count_ff;
                     ins_lo_ff <= VAL_W'(1);
                     ins_hi_ff <= sat31(glo_ff - 34'sd1);
                     state_ff <= S_INS_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  wr_en_ff <= 1'b1;
                  wr_addr_ff <= '0;
                  wr_lo_ff <= VAL_W'(1);
                  wr_hi_ff <= rd_hi;
                  state_ff <= S_DONE;
               end
            end
            S_LOAD: begin
               if (ld_drop_ff) begin
                  state_ff <= S_DONE;
               end else if (count_ff != '0 && ld_lo_ff <= rhi + 34'sd1) begin
                  wr_en_ff <= 1'b1;
                  wr_addr_ff <= AW'(count_ff - CW'(1));
                  wr_lo_ff <= (ld_lo_ff < rlo) ? sat31(ld_lo_ff) : rd_lo;
                  wr_hi_ff <= (ld_hi_ff > rhi) ? sat31(ld_hi_ff) : rd_hi;
                  catchup_ff <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  if (count_ff != '0) begin
                     catchup_ff <= 1'b0;
                  end
                  pos_ff <= count_ff;
                  idx_ff <= count_ff;
                  ins_lo_ff <= sat31(ld_lo_ff);
                  ins_hi_ff <= sat31(ld_hi_ff);
                  state_ff <= S_INS_RD;
               end
            end
            S_DUMP_RD: state_ff <= S_DUMP;
            S_DUMP: begin
               rsp_valid      <= 1'b1;
               rsp_is_read    <= 1'b0;
               rsp_value      <= rd_lo;
               rsp_range_high <= rd_hi;
               rsp_status     <= ST_OK;
               if (idx_ff + CW'(1) >= count_ff || idx_ff + CW'(1) >= OUT_MAX) begin
                  rsp_last <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
                  rd_addr_ff <= AW'(idx_ff + CW'(1));
                  state_ff <= S_DUMP_RD;
               end
            end
            S_DONE: begin
               rsp_valid      <= 1'b1;
               rsp_last       <= 1'b1;
               rsp_is_read    <= is_read_ff;
               rsp_value      <= val_ff;
               rsp_range_high <= '0;
               rsp_status     <= st_ff;
               state_ff       <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
